### sv/spt_pkg.sv
// Package for the sorted priority table: field widths, codes and control structs.
`timescale 1ns / 1ps
package spt_pkg;

  localparam int CMD_W  = 2;
  localparam int VAL_W  = 32;
  localparam int PRI_W  = 16;
  localparam int POS_W  = 4;
  localparam int ST_W   = 3;
  localparam int RPRI_W = 15;
  localparam int CNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_INS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RD  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_NEG   = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_NONE  = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd4;

  typedef struct packed {
    logic start;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic fin;
  } ctl_sts_t;

endpackage

### sv/spt_in_if.sv
// Input channel interface: command beats into the table.
`timescale 1ns / 1ps
interface spt_in_if;
  import spt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] item_value;
  logic signed [PRI_W-1:0] item_priority;
  logic [POS_W-1:0]        position;

  modport source (output valid, command, item_value, item_priority, position, input ready);
  modport sink (input valid, command, item_value, item_priority, position, output ready);

endinterface

### sv/spt_out_if.sv
// Result channel interface: one result beat per command.
`timescale 1ns / 1ps
interface spt_out_if;
  import spt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] read_value;
  logic [RPRI_W-1:0]       read_priority;
  logic [CNT_W-1:0]        entry_count;
  logic [CNT_W-1:0]        removed_count;

  modport source (output valid, status, read_value, read_priority, entry_count,
                  removed_count, input ready);
  modport sink (input valid, status, read_value, read_priority, entry_count,
                removed_count, output ready);

endinterface

### sv/spt_ctrl.sv
// Controller: accepts commands, runs the table scan and owns the result valid.
`timescale 1ns / 1ps
module spt_ctrl
  import spt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t ctl_cmd,
  input  ctl_sts_t ctl_sts
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    ctl_cmd.start = in_valid && in_ready;
    ctl_cmd.step  = (state_r == S_SCAN) && (!ctl_sts.fin || out_free);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (ctl_cmd.start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ctl_cmd.step && ctl_sts.fin) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/spt_datapath.sv
// Datapath: entry memory, occupancy, scan counters, compare and result register.
`timescale 1ns / 1ps
module spt_datapath
  import spt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_cmd_t                 ctl_cmd,
  output ctl_sts_t                 ctl_sts,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [VAL_W-1:0]  in_item_value,
  input  logic signed [PRI_W-1:0]  in_item_priority,
  input  logic [POS_W-1:0]         in_position,
  output logic [ST_W-1:0]          out_status,
  output logic signed [VAL_W-1:0]  out_read_value,
  output logic [RPRI_W-1:0]        out_read_priority,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic [CNT_W-1:0]         out_removed_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] OP_INS  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_RD   = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  logic signed [VAL_W-1:0]  mem_v [DEPTH];
  logic [RPRI_W-1:0]        mem_p [DEPTH];
  logic signed [VAL_W-1:0]  rd_v_r;
  logic [RPRI_W-1:0]        rd_p_r;

  logic [1:0]               op_r, op_nxt;
  logic signed [VAL_W-1:0]  val_r, val_nxt;
  logic [RPRI_W-1:0]        pri_r, pri_nxt;
  logic                     pneg_r, pneg_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [ST_W-1:0]          st_r, st_nxt;
  logic [CW-1:0]            occ_r, occ_nxt;
  logic [CW-1:0]            iss_r, iss_nxt;
  logic                     iss_act_r, iss_act_nxt;
  logic                     dat_vld_r, dat_vld_nxt;
  logic [CW-1:0]            dat_idx_r, dat_idx_nxt;
  logic [CW-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]            rem_r, rem_nxt;

  logic [ST_W-1:0]          res_st_r, res_st_nxt;
  logic signed [VAL_W-1:0]  res_v_r, res_v_nxt;
  logic [RPRI_W-1:0]        res_p_r, res_p_nxt;
  logic [CNT_W-1:0]         res_cnt_r, res_cnt_nxt;
  logic [CNT_W-1:0]         res_rem_r, res_rem_nxt;

  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [VAL_W-1:0]  wr_v;
  logic [RPRI_W-1:0]        wr_p;

  logic                     ent_before;
  logic                     ins_place;
  logic                     del_match;
  logic                     fin;
  logic                     done;
  logic                     in_pneg;
  logic                     tbl_full;
  logic                     pos_ok;

  assign in_pneg  = in_item_priority[PRI_W-1];
  assign tbl_full = (occ_r == CW'(DEPTH));
  assign pos_ok   = (PW'(in_position) < PW'(occ_r));

  assign ent_before = (rd_p_r != pri_r) ? (rd_p_r < pri_r) : (rd_v_r <= val_r);
  assign ins_place  = (dat_idx_r == '0) || ent_before;
  assign del_match  = !pneg_r && (rd_v_r == val_r) && (rd_p_r == pri_r);

  always_comb begin
    unique case (op_r)
      OP_INS:  fin = dat_vld_r && ins_place;
      OP_DEL:  fin = (occ_r == '0) || (dat_vld_r && (dat_idx_r == occ_r - 1'b1));
      OP_RD:   fin = dat_vld_r;
      default: fin = 1'b1;
    endcase
  end

  assign ctl_sts.fin = fin;
  assign done        = ctl_cmd.step && fin;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos_r;
    wr_en   = 1'b0;
    wr_addr = AW'(dat_idx_r);
    wr_v    = rd_v_r;
    wr_p    = rd_p_r;
    unique case (op_r)
      OP_INS: begin
        rd_en   = ctl_cmd.step && iss_act_r && (iss_r != '0);
        rd_addr = AW'(iss_r - 1'b1);
        wr_en   = ctl_cmd.step && dat_vld_r;
        if (ins_place) begin
          wr_v = val_r;
          wr_p = pri_r;
        end
      end
      OP_DEL: begin
        rd_en   = ctl_cmd.step && iss_act_r;
        rd_addr = AW'(iss_r);
        wr_en   = ctl_cmd.step && dat_vld_r && !del_match;
        wr_addr = AW'(wr_ptr_r);
      end
      OP_RD: begin
        rd_en = ctl_cmd.step && iss_act_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_v[wr_addr] <= wr_v;
      mem_p[wr_addr] <= wr_p;
    end
    if (rd_en) begin
      rd_v_r <= mem_v[rd_addr];
      rd_p_r <= mem_p[rd_addr];
    end
  end

  always_comb begin
    op_nxt      = op_r;
    val_nxt     = val_r;
    pri_nxt     = pri_r;
    pneg_nxt    = pneg_r;
    pos_nxt     = pos_r;
    st_nxt      = st_r;
    occ_nxt     = occ_r;
    iss_nxt     = iss_r;
    iss_act_nxt = iss_act_r;
    dat_vld_nxt = dat_vld_r;
    dat_idx_nxt = dat_idx_r;
    wr_ptr_nxt  = wr_ptr_r;
    rem_nxt     = rem_r;
    res_st_nxt  = res_st_r;
    res_v_nxt   = res_v_r;
    res_p_nxt   = res_p_r;
    res_cnt_nxt = res_cnt_r;
    res_rem_nxt = res_rem_r;

    if (ctl_cmd.start) begin
      val_nxt     = in_item_value;
      pri_nxt     = in_item_priority[RPRI_W-1:0];
      pneg_nxt    = in_pneg;
      pos_nxt     = AW'(in_position);
      dat_vld_nxt = 1'b0;
      wr_ptr_nxt  = '0;
      rem_nxt     = '0;
      op_nxt      = OP_NONE;
      st_nxt      = ST_OK;
      iss_nxt     = '0;
      iss_act_nxt = 1'b0;
      unique case (in_command)
        CMD_INS: begin
          if (in_pneg) begin
            st_nxt = ST_NEG;
          end else if (tbl_full) begin
            st_nxt = ST_FULL;
          end else begin
            op_nxt      = OP_INS;
            iss_nxt     = occ_r;
            iss_act_nxt = 1'b1;
          end
        end
        CMD_DEL: begin
          op_nxt      = OP_DEL;
          iss_act_nxt = (occ_r != '0);
        end
        CMD_RD: begin
          if (pos_ok) begin
            op_nxt      = OP_RD;
            iss_act_nxt = 1'b1;
          end else begin
            st_nxt = ST_RANGE;
          end
        end
        CMD_NOP: begin
          op_nxt = OP_NONE;
        end
        default: op_nxt = OP_NONE;
      endcase
    end else if (ctl_cmd.step) begin
      dat_vld_nxt = iss_act_r;
      dat_idx_nxt = iss_r;
      unique case (op_r)
        OP_INS: begin
          if (iss_act_r) begin
            if (iss_r == '0) begin
              iss_act_nxt = 1'b0;
            end else begin
              iss_nxt = iss_r - 1'b1;
            end
          end
        end
        OP_DEL: begin
          if (iss_act_r) begin
            iss_nxt     = iss_r + 1'b1;
            iss_act_nxt = ((iss_r + 1'b1) != occ_r);
          end
          if (dat_vld_r) begin
            if (del_match) begin
              rem_nxt = rem_r + 1'b1;
            end else begin
              wr_ptr_nxt = wr_ptr_r + 1'b1;
            end
          end
        end
        default: begin
          iss_act_nxt = 1'b0;
        end
      endcase

      if (done) begin
        dat_vld_nxt = 1'b0;
        iss_act_nxt = 1'b0;
        res_st_nxt  = st_r;
        res_v_nxt   = '0;
        res_p_nxt   = '0;
        res_rem_nxt = '0;
        unique case (op_r)
          OP_INS: begin
            occ_nxt = occ_r + 1'b1;
          end
          OP_DEL: begin
            occ_nxt     = wr_ptr_nxt;
            res_rem_nxt = CNT_W'(rem_nxt);
            res_st_nxt  = (rem_nxt == '0) ? ST_NONE : ST_OK;
          end
          OP_RD: begin
            res_v_nxt = rd_v_r;
            res_p_nxt = rd_p_r;
          end
          default: begin
            occ_nxt = occ_r;
          end
        endcase
        res_cnt_nxt = CNT_W'(occ_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r      <= OP_NONE;
      occ_r     <= '0;
      iss_act_r <= 1'b0;
      dat_vld_r <= 1'b0;
    end else begin
      op_r      <= op_nxt;
      occ_r     <= occ_nxt;
      iss_act_r <= iss_act_nxt;
      dat_vld_r <= dat_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    pri_r     <= pri_nxt;
    pneg_r    <= pneg_nxt;
    pos_r     <= pos_nxt;
    st_r      <= st_nxt;
    iss_r     <= iss_nxt;
    dat_idx_r <= dat_idx_nxt;
    wr_ptr_r  <= wr_ptr_nxt;
    rem_r     <= rem_nxt;
    res_st_r  <= res_st_nxt;
    res_v_r   <= res_v_nxt;
    res_p_r   <= res_p_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_rem_r <= res_rem_nxt;
  end

  assign out_status        = res_st_r;
  assign out_read_value    = res_v_r;
  assign out_read_priority = res_p_r;
  assign out_entry_count   = res_cnt_r;
  assign out_removed_count = res_rem_r;

endmodule

### sv/sorted_priority_table.sv
// Top level of the sorted priority table: controller plus datapath on two channels.
//
//   channel  dir  beat
//   in_ch    in   command, item_value, item_priority, position
//   out_ch   out  status, read_value, read_priority, entry_count, removed_count
//
// One beat in, one beat out. A read fetches one entry from accept to result; insert
// reads up to n entries and delete all n, n the entries held, walked by the single
// read port of the entry memory at one entry per cycle.
// Reset clears occupancy and control; entry memory is not cleared.
// A new beat is taken while a result waits; a scan holds at its last step
// until the result register is free.
`timescale 1ns / 1ps
module sorted_priority_table
  import spt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  spt_in_if.sink    in_ch,
  spt_out_if.source out_ch
);

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  spt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl_cmd   (ctl_cmd),
    .ctl_sts   (ctl_sts)
  );

  spt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl_cmd           (ctl_cmd),
    .ctl_sts           (ctl_sts),
    .in_command        (in_ch.command),
    .in_item_value     (in_ch.item_value),
    .in_item_priority  (in_ch.item_priority),
    .in_position       (in_ch.position),
    .out_status        (out_ch.status),
    .out_read_value    (out_ch.read_value),
    .out_read_priority (out_ch.read_priority),
    .out_entry_count   (out_ch.entry_count),
    .out_removed_count (out_ch.removed_count)
  );

endmodule
